[hdl/clint_timer_soft_interrupt_core_defines.svh]
// Assertion macros shared by the CLINT checker.
`ifndef CLINT_TIMER_SOFT_INTERRUPT_CORE_DEFINES_SVH
`define CLINT_TIMER_SOFT_INTERRUPT_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CLINT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CLINT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/clint_pkg.sv]
// Types, codes and constants shared by the CLINT timer and soft interrupt block.
`default_nettype none

package clint_pkg;

    localparam int OFFSET_W = 16;
    localparam int ADDR_W   = OFFSET_W + 1;

    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_LOAD    = 2'd3;

    localparam logic [1:0] VIEW_COMBINED = 2'd0;
    localparam logic [1:0] VIEW_SOFT     = 2'd1;
    localparam logic [1:0] VIEW_TIMER    = 2'd2;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_LOAD  = 2'd1;
    localparam logic [1:0] FAULT_STORE = 2'd2;

    localparam logic [3:0] ACCESS_BYTES = 4'd4;
    localparam logic [3:0] HALF_STRIDE  = 4'd4;

    localparam logic [OFFSET_W-1:0] SOFT_OFFSET_DEF    = 16'd0;
    localparam logic [OFFSET_W-1:0] COMPARE_OFFSET_DEF = 16'd16384;
    localparam logic [OFFSET_W-1:0] TIME_OFFSET_DEF    = 16'd49144;

    localparam logic [63:0] TIME_RESET    = '0;
    localparam logic [63:0] COMPARE_RESET = '1;

    typedef struct packed {
        logic [1:0]          command;
        logic [1:0]          view;
        logic [OFFSET_W-1:0] offset;
        logic [3:0]          access_size;
        logic [31:0]         write_data;
        logic [31:0]         advance_delta;
        logic [63:0]         time_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  fault;
        logic        timer_irq;
        logic        soft_irq;
    } rsp_t;

endpackage

`default_nettype wire

[hdl/clint_regfile.sv]
// Time, compare and soft registers with address decode and response formation.
`default_nettype none

module clint_regfile #(
    parameter logic [15:0] SOFT_OFFSET    = clint_pkg::SOFT_OFFSET_DEF,
    parameter logic [15:0] COMPARE_OFFSET = clint_pkg::COMPARE_OFFSET_DEF,
    parameter logic [15:0] TIME_OFFSET    = clint_pkg::TIME_OFFSET_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            commit,
    input  clint_pkg::req_t req,
    output clint_pkg::rsp_t result
);
    import clint_pkg::*;

    localparam logic [ADDR_W-1:0] SOFT_ADDR   = ADDR_W'(SOFT_OFFSET);
    localparam logic [ADDR_W-1:0] CMP_LO_ADDR = ADDR_W'(COMPARE_OFFSET);
    localparam logic [ADDR_W-1:0] CMP_HI_ADDR = ADDR_W'(COMPARE_OFFSET) + ADDR_W'(HALF_STRIDE);
    localparam logic [ADDR_W-1:0] TIME_LO_ADDR = ADDR_W'(TIME_OFFSET);
    localparam logic [ADDR_W-1:0] TIME_HI_ADDR = ADDR_W'(TIME_OFFSET) + ADDR_W'(HALF_STRIDE);

    logic [63:0]       time_reg, time_next;
    logic [63:0]       cmp_reg, cmp_next;
    logic              soft_reg, soft_next;
    logic [ADDR_W-1:0] addr;
    logic              mapped;
    logic              size_ok;
    logic [31:0]       rdata;
    logic [1:0]        fault;

    always_comb
    begin
        addr   = {1'b0, req.offset};
        mapped = 1'b0;
        if (req.view inside {VIEW_COMBINED, VIEW_SOFT})
        begin
            mapped = 1'b1;
        end
        else if (req.view == VIEW_TIMER)
        begin
            addr   = {1'b0, req.offset} + ADDR_W'(COMPARE_OFFSET);
            mapped = 1'b1;
        end
    end

    assign size_ok = (req.access_size == ACCESS_BYTES);

    always_comb
    begin
        time_next = time_reg;
        cmp_next  = cmp_reg;
        soft_next = soft_reg;
        rdata     = '0;
        fault     = FAULT_NONE;
        case (req.command)
            CMD_READ:
            begin
                if (!size_ok)
                    fault = FAULT_LOAD;
                else if (mapped)
                begin
                    if (addr == SOFT_ADDR)
                        rdata = {31'b0, soft_reg};
                    else if (addr == CMP_LO_ADDR)
                        rdata = cmp_reg[31:0];
                    else if (addr == CMP_HI_ADDR)
                        rdata = cmp_reg[63:32];
                    else if (addr == TIME_LO_ADDR)
                        rdata = time_reg[31:0];
                    else if (addr == TIME_HI_ADDR)
                        rdata = time_reg[63:32];
                end
            end
            CMD_WRITE:
            begin
                if (!size_ok)
                    fault = FAULT_STORE;
                else if (mapped)
                begin
                    if (addr == SOFT_ADDR)
                        soft_next = req.write_data[0];
                    else if (addr == CMP_LO_ADDR)
                        cmp_next = {cmp_reg[63:32], req.write_data};
                    else if (addr == CMP_HI_ADDR)
                        cmp_next = {req.write_data, cmp_reg[31:0]};
                    else if (addr == TIME_LO_ADDR)
                        time_next = {time_reg[63:32], req.write_data};
                    else if (addr == TIME_HI_ADDR)
                        time_next = {req.write_data, time_reg[31:0]};
                end
            end
            CMD_ADVANCE:
            begin
                time_next = time_reg + {32'b0, req.advance_delta};
            end
            CMD_LOAD:
            begin
                time_next = req.time_value;
            end
            default:
            begin
                time_next = time_reg;
            end
        endcase
    end

    assign result.read_data = rdata;
    assign result.fault     = fault;
    assign result.timer_irq = (time_next >= cmp_next);
    assign result.soft_irq  = soft_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= TIME_RESET;
            cmp_reg  <= COMPARE_RESET;
            soft_reg <= 1'b0;
        end
        else if (commit)
        begin
            time_reg <= time_next;
            cmp_reg  <= cmp_next;
            soft_reg <= soft_next;
        end
    end

endmodule

`default_nettype wire

[hdl/clint_timer_soft_interrupt_core.sv]
// Core-local interruptor: 64-bit time, 64-bit compare and a software interrupt bit.
// Each request (register read or write, time advance, time load) gives exactly one
// response carrying read data, a fault code and the timer and soft levels seen after
// the request took effect. A request passes an input register, then the register
// update and response are formed combinationally and land in the output register;
// one request is taken every cycle unless the output register is full and stalled.
// The limit is the combinational 64-bit add and time >= compare path into the state
// registers. Responses are never dropped under stall: the input register holds while
// the output register is full and stalled.
`default_nettype none

module clint_timer_soft_interrupt_core #(
    parameter logic [15:0] SOFT_OFFSET    = clint_pkg::SOFT_OFFSET_DEF,
    parameter logic [15:0] COMPARE_OFFSET = clint_pkg::COMPARE_OFFSET_DEF,
    parameter logic [15:0] TIME_OFFSET    = clint_pkg::TIME_OFFSET_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  clint_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output clint_pkg::rsp_t rsp
);
    import clint_pkg::*;

    logic s1_valid_reg;
    req_t s1_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg;
    rsp_t result;
    logic out_open;
    logic s1_move;
    logic req_take;

    assign out_open  = !rsp_valid_reg || !rsp_stall;
    assign s1_move   = s1_valid_reg && out_open;
    assign req_stall = s1_valid_reg && !out_open;
    assign req_take  = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
            s1_reg <= req;
        if (s1_move)
            rsp_reg <= result;
    end

    clint_regfile #(
        .SOFT_OFFSET    (SOFT_OFFSET),
        .COMPARE_OFFSET (COMPARE_OFFSET),
        .TIME_OFFSET    (TIME_OFFSET)
    ) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (s1_move),
        .req    (s1_reg),
        .result (result)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[hdl/clint_checker.sv]
// Port-level checks for the CLINT core, bound to the top level.
`default_nettype none
`include "clint_timer_soft_interrupt_core_defines.svh"

module clint_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input clint_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input clint_pkg::rsp_t rsp
);
    import clint_pkg::*;

    `CLINT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
    `CLINT_ASSERT_NOW(a_fault_no_data, rsp_valid && rsp.fault != FAULT_NONE, rsp.read_data == '0, "faulted response carries data")
    `CLINT_ASSERT_NOW(a_stall_needs_full, req_stall, rsp_valid, "request stalled with empty output")
    `CLINT_ASSERT_NOW(a_req_known, req_valid, !$isunknown(req), "valid request has unknown bits")

endmodule

bind clint_timer_soft_interrupt_core clint_checker u_clint_checker (.*);

`default_nettype wire

[bench/tb_clint_timer_soft_interrupt_core.sv]
// Testbench for the CLINT timer and soft interrupt core: directed table, random traffic, scoreboard.
module tb_clint_timer_soft_interrupt_core;
    timeunit 1ns;
    timeprecision 1ps;

    import clint_pkg::*;

    localparam logic [1:0] VIEW_UNUSED    = 2'd3;
    localparam int         LONG_HOLD      = 80;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         RANDOM_ITEMS   = 375;
    localparam int         CALM_ITEMS     = 60;

    localparam logic [ADDR_W-1:0] A_SOFT    = {1'b0, SOFT_OFFSET_DEF};
    localparam logic [ADDR_W-1:0] A_CMP_LO  = {1'b0, COMPARE_OFFSET_DEF};
    localparam logic [ADDR_W-1:0] A_CMP_HI  = {1'b0, COMPARE_OFFSET_DEF} + ADDR_W'(HALF_STRIDE);
    localparam logic [ADDR_W-1:0] A_TIME_LO = {1'b0, TIME_OFFSET_DEF};
    localparam logic [ADDR_W-1:0] A_TIME_HI = {1'b0, TIME_OFFSET_DEF} + ADDR_W'(HALF_STRIDE);

    typedef struct packed {
        req_t request;
        bit   typed;
        rsp_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // expectation typed into the table travels alongside the request
    bit   req_typed = 1'b0;
    rsp_t req_want = '0;

    logic [63:0] model_time = TIME_RESET;
    logic [63:0] model_compare = COMPARE_RESET;
    logic        model_soft = 1'b0;

    rsp_t pending_responses[$];
    int   mismatches = 0;
    int   checked = 0;
    int   cmd_count[4] = '{0, 0, 0, 0};
    int   fault_count = 0;
    int   timer_high = 0;
    int   soft_high = 0;
    int   idle_cycles = 0;

    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_long = 1'b0;

    clint_timer_soft_interrupt_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rsp_t clint_next_response(input req_t r);
        rsp_t              o;
        logic [ADDR_W-1:0] addr;
        bit                mapped;
        o = '0;
        o.fault = FAULT_NONE;
        addr = '0;
        mapped = 1'b1;
        case (r.view)
            VIEW_COMBINED, VIEW_SOFT: addr = {1'b0, r.offset};
            VIEW_TIMER:               addr = {1'b0, r.offset} + {1'b0, COMPARE_OFFSET_DEF};
            default:                  mapped = 1'b0;
        endcase
        case (r.command)
            CMD_READ:
            begin
                if (r.access_size != ACCESS_BYTES)
                    o.fault = FAULT_LOAD;
                else if (mapped)
                begin
                    if (addr == A_SOFT)
                        o.read_data = {31'b0, model_soft};
                    else if (addr == A_CMP_LO)
                        o.read_data = model_compare[31:0];
                    else if (addr == A_CMP_HI)
                        o.read_data = model_compare[63:32];
                    else if (addr == A_TIME_LO)
                        o.read_data = model_time[31:0];
                    else if (addr == A_TIME_HI)
                        o.read_data = model_time[63:32];
                end
            end
            CMD_WRITE:
            begin
                if (r.access_size != ACCESS_BYTES)
                    o.fault = FAULT_STORE;
                else if (mapped)
                begin
                    if (addr == A_SOFT)
                        model_soft = r.write_data[0];
                    else if (addr == A_CMP_LO)
                        model_compare[31:0] = r.write_data;
                    else if (addr == A_CMP_HI)
                        model_compare[63:32] = r.write_data;
                    else if (addr == A_TIME_LO)
                        model_time[31:0] = r.write_data;
                    else if (addr == A_TIME_HI)
                        model_time[63:32] = r.write_data;
                end
            end
            CMD_ADVANCE: model_time = model_time + {32'b0, r.advance_delta};
            default:     model_time = r.time_value;
        endcase
        o.timer_irq = (model_time >= model_compare);
        o.soft_irq = model_soft;
        return o;
    endfunction

    function automatic row_t table_row(input logic [1:0] cmd, input logic [1:0] view,
                                       input logic [15:0] off, input logic [3:0] size,
                                       input logic [31:0] v32, input logic [63:0] v64,
                                       input bit typed, input logic [31:0] rdata,
                                       input logic [1:0] flt, input logic tirq,
                                       input logic sirq);
        row_t t;
        t.request.command = cmd;
        t.request.view = view;
        t.request.offset = off;
        t.request.access_size = size;
        t.request.write_data = v32;
        t.request.advance_delta = v32;
        t.request.time_value = v64;
        t.typed = typed;
        t.want.read_data = rdata;
        t.want.fault = flt;
        t.want.timer_irq = tirq;
        t.want.soft_irq = sirq;
        return t;
    endfunction

    function automatic req_t random_request();
        req_t              r;
        logic [ADDR_W-1:0] target;
        logic [ADDR_W-1:0] rel;
        int unsigned       pick;
        r.view = 2'($urandom_range(0, 3));
        r.offset = 16'($urandom);
        r.access_size = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 8)) : ACCESS_BYTES;
        r.write_data = $urandom;
        r.advance_delta = $urandom;
        r.time_value = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.command = CMD_READ;
        else if (pick < 65)
            r.command = CMD_WRITE;
        else if (pick < 90)
            r.command = CMD_ADVANCE;
        else
            r.command = CMD_LOAD;
        if ($urandom_range(0, 9) == 0)
            r.write_data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        if ($urandom_range(0, 3) != 0)
            r.advance_delta = $urandom_range(0, 64);
        if ($urandom_range(0, 1) == 0)
            r.time_value = model_compare - 64'($urandom_range(0, 16));
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            case (pick)
                0:       target = A_SOFT;
                1:       target = A_CMP_LO;
                2:       target = A_CMP_HI;
                3, 4:    target = A_TIME_LO;
                default: target = A_TIME_HI;
            endcase
            if (target == A_CMP_HI && $urandom_range(0, 1) == 0)
                r.write_data = model_time[63:32];
            if (target != A_SOFT && $urandom_range(0, 1) == 0)
            begin
                rel = target - A_CMP_LO;
                r.view = VIEW_TIMER;
                r.offset = rel[OFFSET_W-1:0];
            end
            else
            begin
                r.view = $urandom_range(0, 1) ? VIEW_SOFT : VIEW_COMBINED;
                r.offset = target[OFFSET_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic send_request(input req_t r, input bit typed, input rsp_t want);
        req <= r;
        req_typed <= typed;
        req_want <= want;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (sender_idles && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_responses.size() != 0);
    endtask

    task automatic field_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin : scoreboard
        rsp_t want;
        rsp_t pred;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                pred = clint_next_response(req);
                pending_responses.push_back(req_typed ? req_want : pred);
                cmd_count[req.command]++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                checked++;
                if (rsp.fault != FAULT_NONE)
                    fault_count++;
                if (rsp.timer_irq)
                    timer_high++;
                if (rsp.soft_irq)
                    soft_high++;
                if (pending_responses.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: response with none expected, got 0x%0h", $time, rsp);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (rsp.read_data !== want.read_data)
                        field_mismatch("read_data", 64'(want.read_data), 64'(rsp.read_data));
                    if (rsp.fault !== want.fault)
                        field_mismatch("fault", 64'(want.fault), 64'(rsp.fault));
                    if (rsp.timer_irq !== want.timer_irq)
                        field_mismatch("timer_irq", 64'(want.timer_irq), 64'(rsp.timer_irq));
                    if (rsp.soft_irq !== want.soft_irq)
                        field_mismatch("soft_irq", 64'(want.soft_irq), 64'(rsp.soft_irq));
                end
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : response_side
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                rsp_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rsp_stall <= 1'b0;
                hold_long = 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 9) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        row_t rows[$];
        row_t t;
        int   i;

        // reset state, extremes and faults: expectations typed in
        rows.push_back(table_row(CMD_READ, VIEW_COMBINED, TIME_OFFSET_DEF, ACCESS_BYTES, 0, 0,
                                 1, 32'h0, FAULT_NONE, 1'b0, 1'b0));
        rows.push_back(table_row(CMD_READ, VIEW_COMBINED,
                                 COMPARE_OFFSET_DEF + OFFSET_W'(HALF_STRIDE),
                                 ACCESS_BYTES, 0, 0, 1, 32'hFFFF_FFFF, FAULT_NONE, 1'b0, 1'b0));
        rows.push_back(table_row(CMD_READ, VIEW_TIMER, 16'h0, ACCESS_BYTES, 0, 0,
                                 1, 32'hFFFF_FFFF, FAULT_NONE, 1'b0, 1'b0));
        rows.push_back(table_row(CMD_READ, VIEW_COMBINED, SOFT_OFFSET_DEF, 4'd8, 0, 0,
                                 1, 32'h0, FAULT_LOAD, 1'b0, 1'b0));
        rows.push_back(table_row(CMD_WRITE, VIEW_SOFT, SOFT_OFFSET_DEF, 4'd0, 32'h1, 0,
                                 1, 32'h0, FAULT_STORE, 1'b0, 1'b0));
        rows.push_back(table_row(CMD_WRITE, VIEW_TIMER, 16'h0, 4'd8, 32'h0, 0,
                                 1, 32'h0, FAULT_STORE, 1'b0, 1'b0));
        rows.push_back(table_row(CMD_READ, VIEW_UNUSED, 16'h0, ACCESS_BYTES, 0, 0,
                                 1, 32'h0, FAULT_NONE, 1'b0, 1'b0));
        rows.push_back(table_row(CMD_READ, VIEW_TIMER, 16'h4, ACCESS_BYTES, 0, 0,
                                 1, 32'hFFFF_FFFF, FAULT_NONE, 1'b0, 1'b0));
        // remaining rows go through the predictor
        rows.push_back(table_row(CMD_WRITE, VIEW_SOFT, SOFT_OFFSET_DEF, ACCESS_BYTES,
                                 32'hFFFF_FFFF, 0, 0, 0, FAULT_NONE, 0, 0));
        // timer view must not wrap onto the soft bit
        rows.push_back(table_row(CMD_READ, VIEW_TIMER, 16'hC000, ACCESS_BYTES, 0, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_READ, VIEW_TIMER, 16'hFFFF, ACCESS_BYTES, 0, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_UNUSED, 16'h0, ACCESS_BYTES, 32'h0, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_COMBINED, 16'hFFFF, ACCESS_BYTES,
                                 32'hFFFF_FFFF, 0, 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_COMBINED, SOFT_OFFSET_DEF, ACCESS_BYTES,
                                 32'hFFFF_FFFE, 0, 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_TIMER, 16'h0, ACCESS_BYTES, 32'h10, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_TIMER, 16'h4, ACCESS_BYTES, 32'h0, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_ADVANCE, VIEW_COMBINED, 16'h0, ACCESS_BYTES, 32'hF, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_ADVANCE, VIEW_COMBINED, 16'h0, 4'd0, 32'h1, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_LOAD, VIEW_UNUSED, 16'hFFFF, 4'd8, 32'h0,
                                 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, FAULT_NONE, 0, 0));
        // wraps past 2^64
        rows.push_back(table_row(CMD_ADVANCE, VIEW_COMBINED, 16'h0, ACCESS_BYTES, 32'hFFFF_FFFF, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_READ, VIEW_COMBINED,
                                 TIME_OFFSET_DEF + OFFSET_W'(HALF_STRIDE),
                                 ACCESS_BYTES, 0, 0, 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_COMBINED, TIME_OFFSET_DEF, ACCESS_BYTES, 32'h0, 0,
                                 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_TIMER,
                                 TIME_OFFSET_DEF - COMPARE_OFFSET_DEF + OFFSET_W'(HALF_STRIDE),
                                 ACCESS_BYTES, 32'h0, 0, 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_WRITE, VIEW_COMBINED,
                                 COMPARE_OFFSET_DEF + OFFSET_W'(HALF_STRIDE),
                                 ACCESS_BYTES, 32'hFFFF_FFFF, 0, 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_READ, VIEW_TIMER, TIME_OFFSET_DEF - COMPARE_OFFSET_DEF,
                                 ACCESS_BYTES, 0, 0, 0, 0, FAULT_NONE, 0, 0));
        rows.push_back(table_row(CMD_LOAD, VIEW_COMBINED, 16'h0, ACCESS_BYTES, 32'h0, 64'h0,
                                 0, 0, FAULT_NONE, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < rows.size(); i++)
        begin
            t = rows[i];
            send_request(t.request, t.typed, t.want);
        end

        // sender pause until everything is back
        wait_drained();

        // long receiver hold while requests keep coming
        hold_long = 1'b1;
        sender_idles = 1'b0;
        for (i = 0; i < 24; i++)
            send_request(random_request(), 1'b0, '0);
        sender_idles = 1'b1;

        for (i = 0; i < RANDOM_ITEMS - 24 - CALM_ITEMS; i++)
            send_request(random_request(), 1'b0, '0);

        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        for (i = 0; i < CALM_ITEMS; i++)
            send_request(random_request(), 1'b0, '0);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("Run covered %0d reads, %0d writes, %0d advances, %0d loads; %0d checked",
                 cmd_count[CMD_READ], cmd_count[CMD_WRITE], cmd_count[CMD_ADVANCE],
                 cmd_count[CMD_LOAD], checked);
        $display("Faults returned %0d, timer level high %0d, soft level high %0d",
                 fault_count, timer_high, soft_high);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
